// File: src/dqs_scan_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Dollar-quoted string scanner package
// Shared phase type, status codes, byte constants and character-class
// helpers for the dollar-quoted string scanner.
// ----------------------------------------------------------------------------
package dqs_scan_pkg;

    // Default upper bound on stored tag characters.
    localparam int MAX_TAG_CHARS_DEF = 63;

    // Width of the reported tag length field.
    localparam int TAG_LEN_OUT_W = 6;

    // Scan phase of the current attempt.
    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_SPACE = 3'd1,
        PH_TAG   = 3'd2,
        PH_BODY  = 3'd3,
        PH_MATCH = 3'd4
    } t_phase;

    // Result status codes.
    localparam logic [2:0] ST_SKIP   = 3'd0;
    localparam logic [2:0] ST_TAKEN  = 3'd1;
    localparam logic [2:0] ST_DONE   = 3'd2;
    localparam logic [2:0] ST_REJECT = 3'd3;
    localparam logic [2:0] ST_IDLE   = 3'd4;

    // Byte constants.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_HIGH   = 8'h80;

    // Whitespace skipped before the opening dollar sign.
    function automatic logic is_space(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);
    endfunction

    // A letter, an underscore or a byte with the top bit set may open a tag.
    function automatic logic starts_tag(input logic [7:0] b);
        return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A)) ||
               (b == 8'h5F) || (b >= CH_HIGH);
    endfunction

    // Later tag characters may also be decimal digits.
    function automatic logic continues_tag(input logic [7:0] b);
        return starts_tag(b) || ((b >= 8'h30) && (b <= 8'h39));
    endfunction

endpackage
`default_nettype wire

// File: src/dqs_scan_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dqs_scan_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 63,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]  i_wr_data,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule
`default_nettype wire

// File: src/dollar_quoted_string_scanner.sv
`default_nettype none
// A result is registered in the output stage, or in the skid entry while the output is held, before o_valid shows it.
// Throughput: one byte per cycle while o_ready is high; the loop that sets it
// is the phase and match index update, which also addresses the tag store so
// its registered read is ready for the next byte.
// A two-entry output stage keeps input ready high while one result waits.
// Reset (i_rst_n low, synchronous) returns to idle with no scan active.
// ----------------------------------------------------------------------------
// Dollar-quoted string scanner
// Consumes one byte per transfer and tracks a $tag$ ... $tag$ token, giving
// one status result per byte.
// ----------------------------------------------------------------------------
module dollar_quoted_string_scanner #(
    parameter int MAX_TAG_CHARS = dqs_scan_pkg::MAX_TAG_CHARS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_byte_value,
    input  wire logic       i_start_scan,
    input  wire logic       i_token_allowed,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [2:0]      o_status,
    output logic [dqs_scan_pkg::TAG_LEN_OUT_W-1:0] o_tag_length_seen
);
    import dqs_scan_pkg::*;

    localparam int CW = $clog2(MAX_TAG_CHARS + 1);
    localparam int AW = (MAX_TAG_CHARS > 1) ? $clog2(MAX_TAG_CHARS) : 1;
    localparam int LW = TAG_LEN_OUT_W;

    // Scan state.
    t_phase         r_phase,        n_phase;
    logic [CW-1:0]  r_tag_length,   n_tag_length;
    logic [CW-1:0]  r_match_index,  n_match_index;

    // Tag store ports.
    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    logic [7:0]     rd_data;

    // Result of the byte in flight.
    logic [2:0]     new_status;
    logic [LW-1:0]  new_len;
    logic           in_xfer;

    // Output stage and skid entry.
    logic           r_out_valid;
    logic [2:0]     r_out_status;
    logic [LW-1:0]  r_out_len;
    logic           r_skid_valid;
    logic [2:0]     r_skid_status;
    logic [LW-1:0]  r_skid_len;
    logic           out_free;

    assign o_ready  = !r_skid_valid;
    assign in_xfer  = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;

    // Tag store, read every cycle at the match index of the next byte.
    dqs_scan_ram #(
        .WIDTH (8),
        .DEPTH (MAX_TAG_CHARS),
        .ADDR_W(AW)
    ) u_tag_store (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(i_byte_value),
        .i_rd_addr(n_match_index[AW-1:0]),
        .o_rd_data(rd_data)
    );

    // Per-byte scan step: next phase, counters, tag write and status.
    always_comb begin
        t_phase          ph;
        logic [CW-1:0]   tl;
        logic [CW-1:0]   mi;
        logic [2:0]      st;
        logic            body;
        logic            tag_char;
        logic [CW+LW-1:0] len_ext;

        ph       = r_phase;
        tl       = r_tag_length;
        mi       = r_match_index;
        st       = ST_IDLE;
        body     = 1'b0;
        tag_char = 1'b0;
        len_ext  = '0;
        wr_en    = 1'b0;
        wr_addr  = r_tag_length[AW-1:0];
        new_len  = '0;

        if (in_xfer) begin
            if (i_start_scan) begin
                tl = '0;
                mi = '0;
                ph = i_token_allowed ? PH_SPACE : PH_IDLE;
            end

            if (i_start_scan && !i_token_allowed) begin
                st = ST_REJECT;
            end else if (ph == PH_IDLE) begin
                st = ST_IDLE;
            end else begin
                unique case (ph)
                    PH_SPACE: begin
                        if (is_space(i_byte_value)) begin
                            st = ST_SKIP;
                        end else if (i_byte_value == CH_DOLLAR) begin
                            ph = PH_TAG;
                            st = ST_TAKEN;
                        end else begin
                            ph = PH_IDLE;
                            st = ST_REJECT;
                        end
                    end
                    PH_TAG: begin
                        tag_char = (tl == '0) ? starts_tag(i_byte_value)
                                              : continues_tag(i_byte_value);
                        if (tag_char) begin
                            if (tl >= CW'(MAX_TAG_CHARS)) begin
                                ph = PH_IDLE;
                                st = ST_REJECT;
                            end else begin
                                wr_en   = 1'b1;
                                wr_addr = tl[AW-1:0];
                                tl      = tl + CW'(1);
                                st      = ST_TAKEN;
                            end
                        end else if (i_byte_value == CH_DOLLAR) begin
                            ph = PH_BODY;
                            st = ST_TAKEN;
                        end else begin
                            ph = PH_IDLE;
                            st = ST_REJECT;
                        end
                    end
                    PH_BODY: begin
                        body = 1'b1;
                    end
                    PH_MATCH: begin
                        if ((mi < tl) && (i_byte_value == rd_data)) begin
                            mi = mi + CW'(1);
                            st = ST_TAKEN;
                        end else if ((mi == tl) && (i_byte_value == CH_DOLLAR)) begin
                            ph = PH_IDLE;
                            st = ST_DONE;
                        end else begin
                            body = 1'b1;
                        end
                    end
                    default: begin
                        st = ST_IDLE;
                    end
                endcase

                // Ordinary body byte, including a mismatch seen again.
                if (body) begin
                    if (i_byte_value == CH_NUL) begin
                        ph = PH_IDLE;
                        st = ST_REJECT;
                    end else if (i_byte_value == CH_DOLLAR) begin
                        mi = '0;
                        ph = PH_MATCH;
                        st = ST_TAKEN;
                    end else begin
                        ph = PH_BODY;
                        st = ST_TAKEN;
                    end
                end

                len_ext = {{LW{1'b0}}, tl};
                new_len = len_ext[LW-1:0];
            end
        end

        new_status    = st;
        n_phase       = ph;
        n_tag_length  = tl;
        n_match_index = mi;
    end

    // Scan state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_tag_length  <= '0;
            r_match_index <= '0;
        end else begin
            r_phase       <= n_phase;
            r_tag_length  <= n_tag_length;
            r_match_index <= n_match_index;
        end
    end

    // Output stage control: the skid entry fills only while the output is held.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid  <= r_skid_valid || in_xfer;
            r_skid_valid <= 1'b0;
        end else if (in_xfer) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Output stage payload.
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out_status <= r_skid_status;
                r_out_len    <= r_skid_len;
            end else begin
                r_out_status <= new_status;
                r_out_len    <= new_len;
            end
        end else if (in_xfer) begin
            r_skid_status <= new_status;
            r_skid_len    <= new_len;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_status          = r_out_status;
    assign o_tag_length_seen = r_out_len;

endmodule
`default_nettype wire
